[rtl/ngap_pkg.sv]
`default_nettype none

package ngap_pkg;

  // Longest packet handled; a byte beyond it flags the packet
  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned COUNT_W          = 16;
  localparam int unsigned LEN_W            = 14;
  localparam int unsigned NUM_CFG          = 6;
  localparam int unsigned CFG_IDX_W        = 3;

  localparam logic [COUNT_W-1:0] MAX_BYTES      = COUNT_W'(MAX_PACKET_BYTES);
  localparam logic [COUNT_W-1:0] MIN_BYTES      = 16'd8;
  localparam logic [2:0]         MAX_CHOICE     = 3'd2;
  localparam logic [7:0]         MAX_PROC_CODE  = 8'd51;
  localparam logic [LEN_W-1:0]   LEN_SAT        = 14'h3FFF;
  localparam logic [LEN_W-1:0]   GUAMI_MIN_LEN  = 14'd8;
  localparam logic [3:0]         PEND_BYTES     = 4'd8;

  // Register indexes, also the bit of present_mask for that element
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAN_UE_ID  = 3'd0,
    CFG_AMF_UE_ID  = 3'd1,
    CFG_NAS_PDU    = 3'd2,
    CFG_SESSION_ID = 3'd3,
    CFG_GUAMI      = 3'd4,
    CFG_CAUSE      = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_HDR0     = 4'd0,
    PH_HDR1     = 4'd1,
    PH_HDR2     = 4'd2,
    PH_IDHI     = 4'd3,
    PH_IDLO     = 4'd4,
    PH_CRIT     = 4'd5,
    PH_LEN1     = 4'd6,
    PH_LEN2     = 4'd7,
    PH_VALUE    = 4'd8,
    PH_OVERLONG = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSED   = 2'd0,
    ST_REJECTED = 2'd1,
    ST_OVERLONG = 2'd2
  } status_t;

endpackage

`default_nettype wire

[rtl/ngap_pdu_ie_parser.sv]
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// in_      | input     | in_valid/in_stall  | in_packet_byte, in_end_of_packet
// out_     | output    | out_valid/out_stall| out_status .. out_guami_plmn (one per packet)
// cfg_     | input     | cfg_wr_en          | cfg_index, cfg_data (element id registers)
//
// One byte is taken per cycle: the parse state is updated by the byte in the cycle it is
// accepted, and the summary lands in the output register on the edge that takes the last byte.
// Synchronous active-low reset restores the element id registers and clears all packet state.
// While a summary waits on a stalled output, ordinary bytes keep flowing; only a further last
// byte is held until the output register frees up (or is being taken in that cycle).

module ngap_pdu_ie_parser
  import ngap_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_packet_byte,
  input  wire logic                 in_end_of_packet,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic [2:0]                out_pdu_kind,
  output logic [7:0]                out_proc_code,
  output logic [1:0]                out_msg_criticality,
  output logic [13:0]               out_element_count,
  output logic [5:0]                out_present_mask,
  output logic [63:0]               out_ran_ue_id,
  output logic [63:0]               out_amf_ue_id,
  output logic [7:0]                out_session_id,
  output logic [7:0]                out_cause_value,
  output logic [13:0]               out_nas_length,
  output logic [23:0]               out_guami_plmn,

  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  // Element id registers
  logic [15:0] cfg_ie_r [NUM_CFG];

  // Packet parse state
  phase_t             phase_r,   phase_nxt;
  logic [COUNT_W-1:0] cnt_r,     cnt_nxt;
  logic [2:0]         choice_r,  choice_nxt;
  logic [7:0]         code_r,    code_nxt;
  logic [1:0]         crit_r,    crit_nxt;
  logic [15:0]        id_r,      id_nxt;
  logic [5:0]         lenhi_r,   lenhi_nxt;
  logic [LEN_W-1:0]   rem_r,     rem_nxt;
  logic [LEN_W-1:0]   seen_r,    seen_nxt;
  logic [63:0]        pend_r,    pend_nxt;
  logic [7:0]         first_r,   first_nxt;
  logic [LEN_W-1:0]   total_r,   total_nxt;
  logic [63:0]        ran_r,     ran_nxt;
  logic [63:0]        amf_r,     amf_nxt;
  logic [7:0]         sess_r,    sess_nxt;
  logic [7:0]         cause_r,   cause_nxt;
  logic [LEN_W-1:0]   nas_r,     nas_nxt;
  logic [23:0]        plmn_r,    plmn_nxt;
  logic [5:0]         mask_r,    mask_nxt;
  logic               stop_r,    stop_nxt;

  // Summary register
  logic               out_valid_r, out_valid_nxt;
  status_t            o_status_r,  o_status_nxt;
  logic [2:0]         o_choice_r,  o_choice_nxt;
  logic [7:0]         o_code_r,    o_code_nxt;
  logic [1:0]         o_crit_r,    o_crit_nxt;
  logic [LEN_W-1:0]   o_total_r,   o_total_nxt;
  logic [5:0]         o_mask_r,    o_mask_nxt;
  logic [63:0]        o_ran_r,     o_ran_nxt;
  logic [63:0]        o_amf_r,     o_amf_nxt;
  logic [7:0]         o_sess_r,    o_sess_nxt;
  logic [7:0]         o_cause_r,   o_cause_nxt;
  logic [LEN_W-1:0]   o_nas_r,     o_nas_nxt;
  logic [23:0]        o_plmn_r,    o_plmn_nxt;

  logic               in_acc;
  logic               start;
  logic [LEN_W-1:0]   start_len;
  logic               done;
  logic [LEN_W-1:0]   done_len;

  // Hold a last byte only while the summary register is full and stalled
  assign in_stall = out_valid_r & out_stall & in_valid & in_end_of_packet;
  assign in_acc   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ie_r[CFG_RAN_UE_ID]  <= 16'd85;
      cfg_ie_r[CFG_AMF_UE_ID]  <= 16'd10;
      cfg_ie_r[CFG_NAS_PDU]    <= 16'd38;
      cfg_ie_r[CFG_SESSION_ID] <= 16'd0;
      cfg_ie_r[CFG_GUAMI]      <= 16'd28;
      cfg_ie_r[CFG_CAUSE]      <= 16'd15;
    end else if (cfg_wr_en) begin
      // Drop writes beyond the register list
      if (cfg_index < CFG_IDX_W'(NUM_CFG)) begin
        cfg_ie_r[cfg_index] <= cfg_data;
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    choice_nxt = choice_r;
    code_nxt   = code_r;
    crit_nxt   = crit_r;
    id_nxt     = id_r;
    lenhi_nxt  = lenhi_r;
    rem_nxt    = rem_r;
    seen_nxt   = seen_r;
    pend_nxt   = pend_r;
    first_nxt  = first_r;
    total_nxt  = total_r;
    ran_nxt    = ran_r;
    amf_nxt    = amf_r;
    sess_nxt   = sess_r;
    cause_nxt  = cause_r;
    nas_nxt    = nas_r;
    plmn_nxt   = plmn_r;
    mask_nxt   = mask_r;
    stop_nxt   = stop_r;
    start      = 1'b0;
    start_len  = '0;
    done       = 1'b0;
    done_len   = '0;

    // Byte handling
    if (phase_r == PH_OVERLONG) begin
      // Drop everything until the end of the packet
    end else if (cnt_r >= MAX_BYTES) begin
      phase_nxt = PH_OVERLONG;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
      unique case (phase_r)
        PH_HDR0: begin
          choice_nxt = in_packet_byte[7:5];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          code_nxt  = in_packet_byte;
          phase_nxt = PH_HDR2;
        end
        PH_HDR2: begin
          crit_nxt  = in_packet_byte[7:6];
          phase_nxt = PH_IDHI;
        end
        PH_IDHI: begin
          if (!stop_r) begin
            id_nxt    = {in_packet_byte, 8'h00};
            phase_nxt = PH_IDLO;
          end
        end
        PH_IDLO: begin
          if (!stop_r) begin
            id_nxt    = {id_r[15:8], in_packet_byte};
            phase_nxt = PH_CRIT;
          end
        end
        PH_CRIT: begin
          if (!stop_r) begin
            phase_nxt = PH_LEN1;
          end
        end
        PH_LEN1: begin
          if (!stop_r) begin
            priority if (!in_packet_byte[7]) begin
              start     = 1'b1;
              start_len = {7'd0, in_packet_byte[6:0]};
            end else if (!in_packet_byte[6]) begin
              lenhi_nxt = in_packet_byte[5:0];
              phase_nxt = PH_LEN2;
            end else begin
              // Fragmented length form: stop element parsing quietly
              stop_nxt = 1'b1;
            end
          end
        end
        PH_LEN2: begin
          if (!stop_r) begin
            start     = 1'b1;
            start_len = {lenhi_r, in_packet_byte};
          end
        end
        PH_VALUE: begin
          if (!stop_r) begin
            if (seen_r < LEN_W'(PEND_BYTES)) begin
              pend_nxt = {pend_r[55:0], in_packet_byte};
            end
            if (seen_r == '0) begin
              first_nxt = in_packet_byte;
            end
            if (seen_r != LEN_SAT) begin
              seen_nxt = seen_r + 1'b1;
            end
            if (rem_r != '0) begin
              rem_nxt = rem_r - 1'b1;
            end
            if (rem_nxt == '0) begin
              done     = 1'b1;
              done_len = seen_nxt;
            end
          end
        end
        default: begin
          if (!stop_r) begin
            stop_nxt = 1'b1;
          end
        end
      endcase
    end

    // Length known: empty values complete at once
    if (start) begin
      seen_nxt  = '0;
      pend_nxt  = '0;
      first_nxt = '0;
      if (start_len == '0) begin
        done     = 1'b1;
        done_len = '0;
      end else begin
        rem_nxt   = start_len;
        phase_nxt = PH_VALUE;
      end
    end

    // Element complete: count it and update the first matching field
    if (done) begin
      if (total_r != LEN_SAT) begin
        total_nxt = total_r + 1'b1;
      end
      priority if (cfg_ie_r[CFG_RAN_UE_ID] == id_r) begin
        ran_nxt                 = (done_len == '0) ? 64'd0 : pend_nxt;
        mask_nxt[CFG_RAN_UE_ID] = (done_len != '0);
      end else if (cfg_ie_r[CFG_AMF_UE_ID] == id_r) begin
        amf_nxt                 = (done_len == '0) ? 64'd0 : pend_nxt;
        mask_nxt[CFG_AMF_UE_ID] = (done_len != '0);
      end else if (cfg_ie_r[CFG_NAS_PDU] == id_r) begin
        nas_nxt               = done_len;
        mask_nxt[CFG_NAS_PDU] = (done_len != '0);
      end else if (cfg_ie_r[CFG_SESSION_ID] == id_r) begin
        if (done_len != '0) begin
          sess_nxt                 = first_nxt;
          mask_nxt[CFG_SESSION_ID] = 1'b1;
        end
      end else if (cfg_ie_r[CFG_GUAMI] == id_r) begin
        if (done_len < GUAMI_MIN_LEN) begin
          plmn_nxt = '0;
          mask_nxt[CFG_GUAMI] = 1'b0;
        end else begin
          plmn_nxt = pend_nxt[63:40];
          mask_nxt[CFG_GUAMI] = 1'b1;
        end
      end else if (cfg_ie_r[CFG_CAUSE] == id_r) begin
        if (done_len != '0) begin
          cause_nxt           = first_nxt;
          mask_nxt[CFG_CAUSE] = 1'b1;
        end
      end else begin
        // No register matches: count only
      end
      seen_nxt  = '0;
      pend_nxt  = '0;
      first_nxt = '0;
      phase_nxt = PH_IDHI;
    end

    // Summary from the state after this byte
    if ((cnt_nxt < MIN_BYTES) || (choice_nxt > MAX_CHOICE) || (code_nxt > MAX_PROC_CODE)) begin
      o_status_nxt = ST_REJECTED;
    end else if (phase_nxt == PH_OVERLONG) begin
      o_status_nxt = ST_OVERLONG;
    end else begin
      o_status_nxt = ST_PARSED;
    end
    o_choice_nxt = '0;
    o_code_nxt   = '0;
    o_crit_nxt   = '0;
    o_total_nxt  = '0;
    o_mask_nxt   = '0;
    o_ran_nxt    = '0;
    o_amf_nxt    = '0;
    o_sess_nxt   = '0;
    o_cause_nxt  = '0;
    o_nas_nxt    = '0;
    o_plmn_nxt   = '0;
    if (o_status_nxt == ST_PARSED) begin
      o_choice_nxt = choice_nxt;
      o_code_nxt   = code_nxt;
      o_crit_nxt   = crit_nxt;
      o_total_nxt  = total_nxt;
      o_mask_nxt   = mask_nxt;
      o_ran_nxt    = ran_nxt;
      o_amf_nxt    = amf_nxt;
      o_sess_nxt   = sess_nxt;
      o_cause_nxt  = cause_nxt;
      o_nas_nxt    = nas_nxt;
      o_plmn_nxt   = plmn_nxt;
    end

    // Last byte: return all packet state to its idle value
    if (in_end_of_packet) begin
      phase_nxt  = PH_HDR0;
      cnt_nxt    = '0;
      choice_nxt = '0;
      code_nxt   = '0;
      crit_nxt   = '0;
      id_nxt     = '0;
      lenhi_nxt  = '0;
      rem_nxt    = '0;
      seen_nxt   = '0;
      pend_nxt   = '0;
      first_nxt  = '0;
      total_nxt  = '0;
      ran_nxt    = '0;
      amf_nxt    = '0;
      sess_nxt   = '0;
      cause_nxt  = '0;
      nas_nxt    = '0;
      plmn_nxt   = '0;
      mask_nxt   = '0;
      stop_nxt   = 1'b0;
    end

    out_valid_nxt = (in_acc & in_end_of_packet) | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      cnt_r    <= '0;
      choice_r <= '0;
      code_r   <= '0;
      crit_r   <= '0;
      id_r     <= '0;
      lenhi_r  <= '0;
      rem_r    <= '0;
      seen_r   <= '0;
      pend_r   <= '0;
      first_r  <= '0;
      total_r  <= '0;
      ran_r    <= '0;
      amf_r    <= '0;
      sess_r   <= '0;
      cause_r  <= '0;
      nas_r    <= '0;
      plmn_r   <= '0;
      mask_r   <= '0;
      stop_r   <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      choice_r <= choice_nxt;
      code_r   <= code_nxt;
      crit_r   <= crit_nxt;
      id_r     <= id_nxt;
      lenhi_r  <= lenhi_nxt;
      rem_r    <= rem_nxt;
      seen_r   <= seen_nxt;
      pend_r   <= pend_nxt;
      first_r  <= first_nxt;
      total_r  <= total_nxt;
      ran_r    <= ran_nxt;
      amf_r    <= amf_nxt;
      sess_r   <= sess_nxt;
      cause_r  <= cause_nxt;
      nas_r    <= nas_nxt;
      plmn_r   <= plmn_nxt;
      mask_r   <= mask_nxt;
      stop_r   <= stop_nxt;
    end
  end

  // Summary register: load on the last byte, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_end_of_packet) begin
      o_status_r <= o_status_nxt;
      o_choice_r <= o_choice_nxt;
      o_code_r   <= o_code_nxt;
      o_crit_r   <= o_crit_nxt;
      o_total_r  <= o_total_nxt;
      o_mask_r   <= o_mask_nxt;
      o_ran_r    <= o_ran_nxt;
      o_amf_r    <= o_amf_nxt;
      o_sess_r   <= o_sess_nxt;
      o_cause_r  <= o_cause_nxt;
      o_nas_r    <= o_nas_nxt;
      o_plmn_r   <= o_plmn_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_pdu_kind        = o_choice_r;
  assign out_proc_code       = o_code_r;
  assign out_msg_criticality = o_crit_r;
  assign out_element_count   = o_total_r;
  assign out_present_mask    = o_mask_r;
  assign out_ran_ue_id       = o_ran_r;
  assign out_amf_ue_id       = o_amf_r;
  assign out_session_id      = o_sess_r;
  assign out_cause_value     = o_cause_r;
  assign out_nas_length      = o_nas_r;
  assign out_guami_plmn      = o_plmn_r;

endmodule

`default_nettype wire
